[design/hkt_pkg.sv]
// held key tracker package: word types, cell control struct and sizing constants
// no dependencies; used by hkt_cell and held_key_tracker_core
package hkt_pkg;

    localparam int HELD_SLOTS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CODE_W         = 16;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;

    localparam logic OP_KEY     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [CODE_W-1:0]         key_code;
        logic signed [VALUE_W-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]         out_code;
        logic signed [VALUE_W-1:0] out_value;
        logic                      synthetic;
        logic                      last_of_run;
        logic [COUNT_W-1:0]        held_count;
    } out_item_t;

    typedef struct packed {
        logic press_new;   // press of a key not yet in the table
        logic remove;      // release event, table closes the gap at the hit
        logic full;        // table holds every slot
    } cell_ctrl_t;

endpackage

[design/hkt_cell.sv]
// one slot of the held key table: holds a keycode and shifts from its upper neighbor
// depends on hkt_pkg
module hkt_cell
    import hkt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int SLOTS = HELD_SLOTS_DEF,
    parameter int TW    = $clog2(SLOTS + 1)
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [TW-1:0]     total,
    input  logic [CODE_W-1:0] key,
    input  logic [CODE_W-1:0] nbr_code,
    input  logic              hit_in,
    input  logic [CODE_W-1:0] pick_in,
    output logic [CODE_W-1:0] code,
    output logic              hit_out,
    output logic [CODE_W-1:0] pick_out
);

    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic              valid;
    logic              is_top;
    logic              is_dest;
    logic              load;
    logic              shift;

    assign valid    = TW'(INDEX) < total;
    assign hit_out  = hit_in | (valid & (code_reg == key));
    // newest valid entry is picked for the drain
    assign is_top   = TW'(INDEX + 1) == total;
    assign pick_out = is_top ? code_reg : pick_in;
    assign code     = code_reg;

    // new press goes to the free slot, or to the top slot when the table is full
    assign is_dest = ctrl.full ? (INDEX == SLOTS - 1) : (TW'(INDEX) == total);
    assign load    = ctrl.press_new & is_dest;
    assign shift   = (ctrl.remove & hit_out) | (ctrl.press_new & ctrl.full);

    always_comb
    begin
        code_next = code_reg;
        if (load)
        begin
            code_next = key;
        end
        else if (shift)
        begin
            code_next = nbr_code;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

endmodule

[design/held_key_tracker_core.sv]
// held key tracker top level: control sequencer around a chain of hkt_cell slots
// depends on hkt_pkg and hkt_cell
// key event: ST_KEY makes a single compare-and-shift pass over the cell chain and registers the result
// and strobe; a key event while reporting is disabled is dropped with no result and the block stays idle
// release-all: one drain word per cycle (at most MAX_RESULTS words), newest first; no words when empty
// async active-low reset empties the table and enables key reporting; results cannot be stalled
module held_key_tracker_core
    import hkt_pkg::*;
#(
    parameter int HELD_SLOTS = HELD_SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output out_item_t result,
    output logic      result_strobe
);

    localparam int TW   = $clog2(HELD_SLOTS + 1);
    localparam int CNTW = $clog2(MAX_RESULTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KEY   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [TW-1:0]       total_reg;
    logic [TW-1:0]       total_next;
    logic [CNTW-1:0]     cnt_reg;
    logic [CNTW-1:0]     cnt_next;
    logic                enable_reg;
    logic [CODE_W-1:0]   key_reg;
    logic [VALUE_W-1:0]  value_reg;
    out_item_t           result_reg;
    out_item_t           result_next;
    logic                strobe_reg;
    logic                strobe_next;

    logic                accept;
    logic                press;
    logic                full;
    logic                any_hit;
    logic                drain_last;
    logic [TW-1:0]       total_dec;
    cell_ctrl_t          ctrl;

    logic [CODE_W-1:0]   cell_code [HELD_SLOTS];
    logic                hit_chain [HELD_SLOTS+1];
    logic [CODE_W-1:0]   pick_chain [HELD_SLOTS+1];

    assign hit_chain[0]  = 1'b0;
    assign pick_chain[0] = '0;

    for (genvar j = 0; j < HELD_SLOTS; j++)
    begin : g_cell
        logic [CODE_W-1:0] nbr;
        if (j < HELD_SLOTS - 1)
        begin : g_mid
            assign nbr = cell_code[j+1];
        end
        else
        begin : g_end
            assign nbr = '0;
        end

        hkt_cell #(
            .INDEX (j),
            .SLOTS (HELD_SLOTS),
            .TW    (TW)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .total    (total_reg),
            .key      (key_reg),
            .nbr_code (nbr),
            .hit_in   (hit_chain[j]),
            .pick_in  (pick_chain[j]),
            .code     (cell_code[j]),
            .hit_out  (hit_chain[j+1]),
            .pick_out (pick_chain[j+1])
        );
    end

    assign busy    = state_reg != ST_IDLE;
    assign accept  = start & ~busy;
    assign press   = value_reg != '0;
    assign full    = total_reg == TW'(HELD_SLOTS);
    assign any_hit = hit_chain[HELD_SLOTS];
    assign total_dec = total_reg - 1'b1;
    assign drain_last = (total_dec == '0) || (cnt_reg == CNTW'(MAX_RESULTS - 1));

    always_comb
    begin
        ctrl.press_new = (state_reg == ST_KEY) & press & ~any_hit;
        ctrl.remove    = (state_reg == ST_KEY) & ~press;
        ctrl.full      = full;
    end

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        strobe_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (item.opcode == OP_RELEASE)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (enable_reg)
                    begin
                        state_next = ST_KEY;
                    end
                end
            end
            ST_KEY:
            begin
                if (press)
                begin
                    if (!any_hit && !full)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                else if (any_hit)
                begin
                    total_next = total_dec;
                end
                result_next.out_code    = key_reg;
                result_next.out_value   = value_reg;
                result_next.synthetic   = 1'b0;
                result_next.last_of_run = 1'b1;
                result_next.held_count  = COUNT_W'(total_next);
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (total_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    total_next = total_dec;
                    cnt_next   = cnt_reg + 1'b1;
                    result_next.out_code    = pick_chain[HELD_SLOTS];
                    result_next.out_value   = '0;
                    result_next.synthetic   = 1'b1;
                    result_next.last_of_run = drain_last;
                    result_next.held_count  = COUNT_W'(total_dec);
                    strobe_next = 1'b1;
                    if (drain_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            total_reg  <= '0;
            cnt_reg    <= '0;
            enable_reg <= 1'b1;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            key_reg   <= item.key_code;
            value_reg <= item.key_value;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule
